// ===== sv/pl0ts_pkg.sv =====
// Shared types, constants and helper functions for the PL/0 token scanner.
package pl0ts_pkg;

   // Token text storage
   localparam int MAX_TOKEN_CHARS = 16;
   localparam int COUNT_W         = $clog2(MAX_TOKEN_CHARS + 1);
   localparam int INDEX_W         = $clog2(MAX_TOKEN_CHARS);
   localparam int SHOWN_CHARS     = (MAX_TOKEN_CHARS < 16) ? MAX_TOKEN_CHARS : 16;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Token kinds
   localparam logic [4:0] KIND_ERROR  = 5'd0;
   localparam logic [4:0] KIND_NUMBER = 5'd1;
   localparam logic [4:0] KIND_IDENT  = 5'd2;
   localparam logic [4:0] KIND_KW0    = 5'd3;
   localparam logic [4:0] KIND_ADD    = 5'd15;
   localparam logic [4:0] KIND_SUB    = 5'd16;
   localparam logic [4:0] KIND_MUL    = 5'd17;
   localparam logic [4:0] KIND_DIV    = 5'd18;
   localparam logic [4:0] KIND_COMMA  = 5'd19;
   localparam logic [4:0] KIND_COLON  = 5'd20;
   localparam logic [4:0] KIND_SEMI   = 5'd21;
   localparam logic [4:0] KIND_NE     = 5'd22;
   localparam logic [4:0] KIND_GT     = 5'd23;
   localparam logic [4:0] KIND_GE     = 5'd24;
   localparam logic [4:0] KIND_LT     = 5'd25;
   localparam logic [4:0] KIND_LE     = 5'd26;
   localparam logic [4:0] KIND_ASSIGN = 5'd27;
   localparam logic [4:0] KIND_EQ     = 5'd28;
   localparam logic [4:0] KIND_LPAR   = 5'd29;
   localparam logic [4:0] KIND_RPAR   = 5'd30;
   localparam logic [4:0] KIND_END    = 5'd31;

   // Character codes
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_UP_A  = 8'd65;
   localparam logic [7:0] CH_UP_Z  = 8'd90;
   localparam logic [7:0] CH_LO_A  = 8'd97;
   localparam logic [7:0] CH_LO_Z  = 8'd122;
   localparam logic [7:0] CH_CASE  = 8'd32;
   localparam logic [7:0] CH_UNDER = 8'd95;
   localparam logic [7:0] CH_BANG  = 8'd33;
   localparam logic [7:0] CH_LT    = 8'd60;
   localparam logic [7:0] CH_EQ    = 8'd61;
   localparam logic [7:0] CH_GT    = 8'd62;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_COLON = 8'd58;
   localparam logic [7:0] CH_SEMI  = 8'd59;
   localparam logic [7:0] CH_LPAR  = 8'd40;
   localparam logic [7:0] CH_RPAR  = 8'd41;

   localparam logic [35:0] DECIMAL_BASE = 36'd10;

   // Keywords, right-justified strings, with their lengths
   localparam int KW_COUNT = 12;
   localparam int KW_MAX   = 9;
   localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
      "CONST", "VAR", "PROCEDURE", "CALL", "BEGIN", "END",
      "IF", "ELSE", "WHILE", "ODD", "PRINT", "SCAN"
   };
   localparam int KW_LEN [KW_COUNT] = '{5, 3, 9, 4, 5, 3, 2, 4, 5, 3, 5, 4};

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ERR,
      MODE_NUM,
      MODE_WORD,
      MODE_GT,
      MODE_LT,
      MODE_EQ,
      MODE_BANG
   } scan_mode_type;

   typedef logic [MAX_TOKEN_CHARS-1:0][7:0] text_buf_type;
   typedef logic [COUNT_W-1:0]              text_count_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] value;
      logic [63:0] text_low;
      logic [63:0] text_high;
      logic [4:0]  length;
      logic        ovf;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } scan_out_type;

   function automatic logic is_ws(logic [7:0] ch);
      return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   endfunction

   function automatic logic is_digit(logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   function automatic logic is_alpha(logic [7:0] ch);
      return ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) || ((ch >= CH_LO_A) && (ch <= CH_LO_Z));
   endfunction

   function automatic logic is_single(logic [7:0] ch);
      return (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH) ||
             (ch == CH_COMMA) || (ch == CH_COLON) || (ch == CH_SEMI) ||
             (ch == CH_LPAR) || (ch == CH_RPAR);
   endfunction

   function automatic logic [4:0] single_kind(logic [7:0] ch);
      logic [4:0] kind;
      kind = KIND_ERROR;
      unique case (ch)
         CH_PLUS:  kind = KIND_ADD;
         CH_MINUS: kind = KIND_SUB;
         CH_STAR:  kind = KIND_MUL;
         CH_SLASH: kind = KIND_DIV;
         CH_COMMA: kind = KIND_COMMA;
         CH_COLON: kind = KIND_COLON;
         CH_SEMI:  kind = KIND_SEMI;
         CH_LPAR:  kind = KIND_LPAR;
         CH_RPAR:  kind = KIND_RPAR;
         default:  kind = KIND_ERROR;
      endcase
      return kind;
   endfunction

   function automatic logic is_valid(logic [7:0] ch);
      return is_ws(ch) || is_digit(ch) || is_alpha(ch) || (ch == CH_UNDER) ||
             (ch == CH_BANG) || (ch == CH_LT) || (ch == CH_GT) || (ch == CH_EQ) ||
             is_single(ch);
   endfunction

   function automatic logic [7:0] upcase(logic [7:0] ch);
      return ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) ? ch - CH_CASE : ch;
   endfunction

   // Case-insensitive keyword lookup; a truncated word is always an identifier
   function automatic logic [4:0] keyword_kind(text_buf_type tb, text_count_type cnt,
                                               logic ovf);
      logic [4:0] kind;
      logic       same;
      logic [7:0] want;
      int         k;
      int         j;
      kind = KIND_IDENT;
      for (k = 0; k < KW_COUNT; k++) begin
         same = (KW_LEN[k] == int'(cnt));
         for (j = 0; j < KW_MAX; j++) begin
            if (j < KW_LEN[k]) begin
               want = KW_TEXT[k][8*(KW_LEN[k]-1-j) +: 8];
               if (upcase(tb[j]) != want) begin
                  same = 1'b0;
               end
            end
         end
         if (same && !ovf) begin
            kind = KIND_KW0 + 5'(k);
         end
      end
      return kind;
   endfunction

   // Build one result word; bytes at or past the count read as zero
   function automatic rsp_type make_rsp(logic [4:0] kind, text_buf_type tb,
                                        text_count_type cnt, logic [31:0] acc, logic ovf);
      rsp_type      r;
      logic [127:0] text;
      int           j;
      text = '0;
      for (j = 0; j < SHOWN_CHARS; j++) begin
         if (j < int'(cnt)) begin
            text[8*j +: 8] = tb[j];
         end
      end
      r.kind      = kind;
      r.value     = (kind == KIND_NUMBER) ? acc : 32'd0;
      r.text_low  = text[63:0];
      r.text_high = text[127:64];
      r.length    = (int'(cnt) > 31) ? 5'd31 : 5'(cnt);
      r.ovf       = ovf;
      r.last      = 1'b0;
      return r;
   endfunction

endpackage

// ===== sv/pl0_token_scanner_core.sv =====
// Top level of the PL/0 token scanner: input register, scanner, result queue.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+------------------------------------------
//   req     | in        | req_valid/req_stall  | char_code, end_of_input
//   rsp     | out       | rsp_valid/rsp_stall  | token_kind, number_value, text_low/high,
//           |           |                      | text_length, overflow, last
//
// One source byte per cycle while the queue has room: a byte taken at an edge is held in the
// input register and scanned from there, and its tokens (zero, one or two words) enter a
// four-word result queue at the edge that consumes it, and show on rsp from that queue. The
// result port sets the rate: a byte that closes two tokens delivers them one word at a time.
// The input register holds (req_stall high) while fewer than two queue slots are free. Reset
// is synchronous: scanner idle, queue empty. rsp_stall holds the head word in place.
module pl0_token_scanner_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [31:0] rsp_number_value,
   output logic [63:0] rsp_text_low,
   output logic [63:0] rsp_text_high,
   output logic [4:0]  rsp_text_length,
   output logic        rsp_overflow,
   output logic        rsp_last
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_eoi_ff;
   logic       req_take;
   logic       consume;

   pl0ts_pkg::scan_out_type            scan_result;
   logic [1:0]                         push_count;
   pl0ts_pkg::rsp_type                 head;
   logic                               not_empty;
   logic [pl0ts_pkg::RSP_CNT_W-1:0]    fill;
   logic                               pop;

   // Advance the held word only when the queue can absorb two results
   assign consume   = in_valid_ff &&
                      (int'(fill) <= pl0ts_pkg::RSP_DEPTH - 2);
   assign req_stall = in_valid_ff && !consume;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the payload on acceptance; hold it otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_code;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   pl0ts_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (consume),
      .char_code    (in_char_ff),
      .end_of_input (in_eoi_ff),
      .result       (scan_result)
   );

   // Drop the scanner's results unless the byte is actually consumed
   assign push_count = consume ? scan_result.count : 2'd0;
   assign pop        = not_empty && !rsp_stall;

   pl0ts_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (scan_result.first),
      .push_second (scan_result.second),
      .pop         (pop),
      .head        (head),
      .not_empty   (not_empty),
      .fill        (fill)
   );

   assign rsp_valid        = not_empty;
   assign rsp_token_kind   = head.kind;
   assign rsp_number_value = head.value;
   assign rsp_text_low     = head.text_low;
   assign rsp_text_high    = head.text_high;
   assign rsp_text_length  = head.length;
   assign rsp_overflow     = head.ovf;
   assign rsp_last         = head.last;

`ifndef NO_ASSERTIONS
   // Queue occupancy never exceeds its depth
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      int'(fill) <= pl0ts_pkg::RSP_DEPTH)
      else $error("result queue overfilled");

   // A consumed byte never pushes more words than there are free slots
   a_push_room : assert property (@(posedge clock) disable iff (reset)
      consume |-> (int'(fill) + int'(scan_result.count) <= pl0ts_pkg::RSP_DEPTH))
      else $error("result push exceeds free queue space");

   // End marker closes with an end token flagged last
   a_end_token : assert property (@(posedge clock) disable iff (reset)
      (consume && in_eoi_ff) |->
         ((scan_result.count == 2'd1 && scan_result.first.kind == pl0ts_pkg::KIND_END &&
           scan_result.first.last) ||
          (scan_result.count == 2'd2 && scan_result.second.kind == pl0ts_pkg::KIND_END &&
           scan_result.second.last)))
      else $error("end marker did not produce a final end token");
`endif

endmodule

// ===== sv/pl0ts_rsp_fifo.sv =====
// Result queue: takes up to two words per cycle, delivers one per cycle when popped.
module pl0ts_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     push_count,
   input  pl0ts_pkg::rsp_type             push_first,
   input  pl0ts_pkg::rsp_type             push_second,
   input  logic                           pop,
   output pl0ts_pkg::rsp_type             head,
   output logic                           not_empty,
   output logic [pl0ts_pkg::RSP_CNT_W-1:0] fill
);

   pl0ts_pkg::rsp_type                   slot_ff [pl0ts_pkg::RSP_DEPTH];
   logic [pl0ts_pkg::RSP_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [pl0ts_pkg::RSP_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [pl0ts_pkg::RSP_CNT_W-1:0]      fill_ff, fill_in;
   logic [pl0ts_pkg::RSP_PTR_W-1:0]      wr_next_ptr;

   assign wr_next_ptr = wr_ptr_ff + 1'b1;
   assign head        = slot_ff[rd_ptr_ff];
   assign not_empty   = (fill_ff != '0);
   assign fill        = fill_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + pl0ts_pkg::RSP_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + pl0ts_pkg::RSP_PTR_W'(pop);
      fill_in   = fill_ff + pl0ts_pkg::RSP_CNT_W'(push_count) - pl0ts_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         slot_ff[wr_next_ptr] <= push_second;
      end
   end

endmodule

// ===== sv/pl0ts_scan.sv =====
// Scanner state and single-pass token decode for one source byte.
module pl0ts_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              char_code,
   input  logic                    end_of_input,
   output pl0ts_pkg::scan_out_type result
);

   pl0ts_pkg::scan_mode_type  mode_ff, mode_in;
   pl0ts_pkg::text_buf_type   text_ff, text_in;
   pl0ts_pkg::text_count_type count_ff, count_in;
   logic [31:0]               acc_ff, acc_in;
   logic                      ovf_ff, ovf_in;

   // Character classes
   logic ch_ws, ch_digit, ch_alpha, ch_word, ch_valid, ch_single, ch_eq;
   logic op_mode, cont, op_pair, pending;

   // Appended and fresh token views
   logic                      full;
   pl0ts_pkg::text_buf_type   app_text, fresh_text;
   pl0ts_pkg::text_count_type app_count;
   logic                      app_ovf;
   logic [7:0]                digit_diff;
   logic [35:0]               digit_sum;
   logic                      digit_sat;
   logic [31:0]               digit_acc;

   logic [4:0]          pend_kind, op_kind;
   pl0ts_pkg::rsp_type  pend_rsp, op_rsp, single_rsp, end_rsp;

   assign ch_ws     = pl0ts_pkg::is_ws(char_code);
   assign ch_digit  = pl0ts_pkg::is_digit(char_code);
   assign ch_alpha  = pl0ts_pkg::is_alpha(char_code);
   assign ch_word   = ch_alpha || ch_digit || (char_code == pl0ts_pkg::CH_UNDER);
   assign ch_valid  = pl0ts_pkg::is_valid(char_code);
   assign ch_single = pl0ts_pkg::is_single(char_code);
   assign ch_eq     = (char_code == pl0ts_pkg::CH_EQ);

   assign op_mode = (mode_ff == pl0ts_pkg::MODE_GT) || (mode_ff == pl0ts_pkg::MODE_LT) ||
                    (mode_ff == pl0ts_pkg::MODE_EQ) || (mode_ff == pl0ts_pkg::MODE_BANG);
   assign pending = (mode_ff != pl0ts_pkg::MODE_IDLE);

   // Byte extends the pending token
   assign cont = !end_of_input &&
                 (((mode_ff == pl0ts_pkg::MODE_ERR) && !ch_valid) ||
                  ((mode_ff == pl0ts_pkg::MODE_NUM) && ch_digit) ||
                  ((mode_ff == pl0ts_pkg::MODE_WORD) && ch_word) ||
                  (op_mode && ch_eq));
   assign op_pair = cont && op_mode;

   // Append path
   assign full = (int'(count_ff) >= pl0ts_pkg::MAX_TOKEN_CHARS);
   always_comb begin
      app_text = text_ff;
      if (!full) begin
         app_text[count_ff[pl0ts_pkg::INDEX_W-1:0]] = char_code;
      end
   end
   assign app_count = full ? count_ff : pl0ts_pkg::text_count_type'(count_ff + 1'b1);
   assign app_ovf   = ovf_ff || full;

   assign digit_diff = char_code - pl0ts_pkg::CH_ZERO;
   assign digit_sum  = 36'(acc_ff) * pl0ts_pkg::DECIMAL_BASE + 36'(digit_diff[3:0]);
   assign digit_sat  = (digit_sum[35:32] != 4'd0);
   assign digit_acc  = digit_sat ? 32'hFFFF_FFFF : digit_sum[31:0];

   // Fresh token starting with this byte
   always_comb begin
      fresh_text    = text_ff;
      fresh_text[0] = char_code;
   end

   always_comb begin
      unique case (mode_ff)
         pl0ts_pkg::MODE_NUM:  pend_kind = pl0ts_pkg::KIND_NUMBER;
         pl0ts_pkg::MODE_WORD: pend_kind = pl0ts_pkg::keyword_kind(text_ff, count_ff, ovf_ff);
         pl0ts_pkg::MODE_GT:   pend_kind = pl0ts_pkg::KIND_GT;
         pl0ts_pkg::MODE_LT:   pend_kind = pl0ts_pkg::KIND_LT;
         pl0ts_pkg::MODE_EQ:   pend_kind = pl0ts_pkg::KIND_ASSIGN;
         default:              pend_kind = pl0ts_pkg::KIND_ERROR;
      endcase
   end

   always_comb begin
      unique case (mode_ff)
         pl0ts_pkg::MODE_GT: op_kind = pl0ts_pkg::KIND_GE;
         pl0ts_pkg::MODE_LT: op_kind = pl0ts_pkg::KIND_LE;
         pl0ts_pkg::MODE_EQ: op_kind = pl0ts_pkg::KIND_EQ;
         default:            op_kind = pl0ts_pkg::KIND_NE;
      endcase
   end

   assign pend_rsp   = pl0ts_pkg::make_rsp(pend_kind, text_ff, count_ff, acc_ff, ovf_ff);
   assign op_rsp     = pl0ts_pkg::make_rsp(op_kind, app_text, app_count, acc_ff, app_ovf);
   assign single_rsp = pl0ts_pkg::make_rsp(pl0ts_pkg::single_kind(char_code), fresh_text,
                                           pl0ts_pkg::text_count_type'(1), 32'd0, 1'b0);
   assign end_rsp    = pl0ts_pkg::make_rsp(pl0ts_pkg::KIND_END, text_ff,
                                           pl0ts_pkg::text_count_type'(0), 32'd0, 1'b0);

   // Next scan mode
   always_comb begin
      mode_in = mode_ff;
      if (step) begin
         priority if (end_of_input) begin
            mode_in = pl0ts_pkg::MODE_IDLE;
         end else if (op_pair) begin
            mode_in = pl0ts_pkg::MODE_IDLE;
         end else if (cont) begin
            mode_in = mode_ff;
         end else if (ch_ws) begin
            mode_in = pl0ts_pkg::MODE_IDLE;
         end else if (!ch_valid) begin
            mode_in = pl0ts_pkg::MODE_ERR;
         end else if (ch_digit) begin
            mode_in = pl0ts_pkg::MODE_NUM;
         end else if (ch_alpha || (char_code == pl0ts_pkg::CH_UNDER)) begin
            mode_in = pl0ts_pkg::MODE_WORD;
         end else if (char_code == pl0ts_pkg::CH_GT) begin
            mode_in = pl0ts_pkg::MODE_GT;
         end else if (char_code == pl0ts_pkg::CH_LT) begin
            mode_in = pl0ts_pkg::MODE_LT;
         end else if (ch_eq) begin
            mode_in = pl0ts_pkg::MODE_EQ;
         end else if (char_code == pl0ts_pkg::CH_BANG) begin
            mode_in = pl0ts_pkg::MODE_BANG;
         end else begin
            mode_in = pl0ts_pkg::MODE_IDLE;
         end
      end
   end

   // Next token text, count, value and overflow
   always_comb begin
      text_in  = text_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      if (step) begin
         priority if (end_of_input) begin
            count_in = '0;
            acc_in   = '0;
            ovf_in   = 1'b0;
         end else if (cont) begin
            text_in  = app_text;
            count_in = app_count;
            if (mode_ff == pl0ts_pkg::MODE_NUM) begin
               acc_in = digit_acc;
               ovf_in = app_ovf || digit_sat;
            end else begin
               ovf_in = app_ovf;
            end
         end else if (!ch_ws) begin
            text_in  = fresh_text;
            count_in = pl0ts_pkg::text_count_type'(1);
            acc_in   = ch_digit ? 32'(digit_diff[3:0]) : 32'd0;
            ovf_in   = 1'b0;
         end else begin
            text_in = text_ff;
         end
      end
   end

   // Results caused by this byte, in order
   always_comb begin
      result.count  = 2'd0;
      result.first  = end_rsp;
      result.second = end_rsp;
      if (end_of_input) begin
         if (pending) begin
            result.count = 2'd2;
            result.first = pend_rsp;
         end else begin
            result.count = 2'd1;
         end
      end else if (op_pair) begin
         result.count = 2'd1;
         result.first = op_rsp;
      end else if (!cont) begin
         if (pending) begin
            result.first  = pend_rsp;
            result.second = single_rsp;
            result.count  = (ch_single && !ch_ws) ? 2'd2 : 2'd1;
         end else if (ch_single) begin
            result.first = single_rsp;
            result.count = 2'd1;
         end
      end
      result.first.last  = (result.count == 2'd1);
      result.second.last = (result.count == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= pl0ts_pkg::MODE_IDLE;
         count_ff <= '0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      text_ff <= text_in;
   end

endmodule
